// ----- rtl/ikey_pkg.sv -----
// ----------------------------------------------------------------------------
// ikey_pkg
// Shared types and constants of the iambic keyer: phase and element codes,
// register indexes, configuration and divider request bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package ikey_pkg;

  // widths
  localparam int TIME_W = 32;
  localparam int LEN_W  = 20;   // longest phase is a dash of 720000 us
  localparam int DOT_W  = 18;   // longest dot is 240000 us
  localparam int DEB_W  = 14;
  localparam int PCT_W  = 7;
  localparam int WPM_W  = 6;
  localparam int IDX_W  = 3;
  localparam int CFG_W  = 14;

  // shared divider: dividend elapsed*100 or dot base, divisor phase length or speed
  localparam int DIV_NW = 39;
  localparam int DIV_DW = 20;
  localparam int CNT_W  = 6;

  // constants
  localparam logic [DIV_NW-1:0] DOT_BASE_US  = 39'd1200000;
  localparam logic [DOT_W-1:0]  DOT_RESET_US = 18'd60000;
  localparam logic [PCT_W-1:0]  PCT_FULL     = 7'd100;
  localparam logic [WPM_W-1:0]  WPM_MIN      = 6'd5;
  localparam logic [WPM_W-1:0]  WPM_MAX      = 6'd60;
  localparam logic [DEB_W-1:0]  DEB_MIN      = 14'd100;
  localparam logic [DEB_W-1:0]  DEB_MAX      = 14'd10000;
  localparam logic [DEB_W-1:0]  DEB_RESET    = 14'd1000;

  // register indexes
  localparam logic [IDX_W-1:0] REG_WPM        = 3'd0;
  localparam logic [IDX_W-1:0] REG_MODE       = 3'd1;
  localparam logic [IDX_W-1:0] REG_WIN_OPEN   = 3'd2;
  localparam logic [IDX_W-1:0] REG_WIN_CLOSE  = 3'd3;
  localparam logic [IDX_W-1:0] REG_DEBOUNCE   = 3'd4;

  typedef enum logic [1:0] {
    EL_NONE = 2'd0,
    EL_DOT  = 2'd1,
    EL_DASH = 2'd2
  } elem_t;

  typedef enum logic [1:0] {
    MODE_IAMBIC_A  = 2'd0,
    MODE_IAMBIC_B  = 2'd1,
    MODE_ULTIMATIC = 2'd2
  } mode_t;

  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_DOT  = 4'b0010,
    PH_DASH = 4'b0100,
    PH_GAP  = 4'b1000
  } phase_t;

  typedef struct packed {
    mode_t             mode;
    logic [PCT_W-1:0]  win_open;
    logic [PCT_W-1:0]  win_close;
    logic [DEB_W-1:0]  debounce;
  } cfg_t;

  typedef struct packed {
    logic              wr;
    logic [WPM_W-1:0]  wpm;
  } spd_wr_t;

  typedef struct packed {
    logic               start;
    logic [DIV_NW-1:0]  dividend;
    logic [DIV_DW-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [DIV_NW-1:0]  quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/ikey_div.sv -----
// ----------------------------------------------------------------------------
// ikey_div
// Shared restoring divider, one quotient bit per cycle. Serves both the
// dot length on a speed write and the element progress percentage.
// ----------------------------------------------------------------------------
`default_nettype none

module ikey_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ikey_pkg::div_req_t req,
  output ikey_pkg::div_rsp_t     rsp
);
  import ikey_pkg::*;

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DIV_DW-1:0] rem_r;
  logic [DIV_NW-1:0] quo_r;
  logic [DIV_DW-1:0] dsr_r;

  logic [DIV_DW:0]   trial;
  logic [DIV_DW:0]   diff;
  logic              fits;

  // one trial subtraction per cycle
  assign trial = {rem_r, quo_r[DIV_NW-1]};
  assign fits  = trial >= {1'b0, dsr_r};
  assign diff  = trial - {1'b0, dsr_r};

  // sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_NW - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      dsr_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= fits ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
      quo_r <= {quo_r[DIV_NW-2:0], fits};
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

`default_nettype wire

// ----- rtl/ikey_cfg.sv -----
// ----------------------------------------------------------------------------
// ikey_cfg
// Configuration registers with range checks and saturation. A speed write
// is passed on so the dot length can be recomputed.
// ----------------------------------------------------------------------------
`default_nettype none

module ikey_cfg (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        wr_en,
  input  wire logic [ikey_pkg::IDX_W-1:0]  wr_index,
  input  wire logic [ikey_pkg::CFG_W-1:0]  wr_data,
  output ikey_pkg::cfg_t                   cfg,
  output ikey_pkg::spd_wr_t                spd
);
  import ikey_pkg::*;

  mode_t             mode_r;
  logic [PCT_W-1:0]  open_r;
  logic [PCT_W-1:0]  close_r;
  logic [DEB_W-1:0]  deb_r;

  logic [WPM_W-1:0]  wpm_raw;
  logic [WPM_W-1:0]  wpm_sat;
  logic [DEB_W-1:0]  deb_raw;
  logic [DEB_W-1:0]  deb_sat;
  logic [PCT_W-1:0]  pct_raw;

  // saturation of speed and debounce
  assign wpm_raw = wr_data[WPM_W-1:0];
  assign wpm_sat = (wpm_raw < WPM_MIN) ? WPM_MIN :
                   (wpm_raw > WPM_MAX) ? WPM_MAX : wpm_raw;
  assign deb_raw = wr_data[DEB_W-1:0];
  assign deb_sat = (deb_raw < DEB_MIN) ? DEB_MIN :
                   (deb_raw > DEB_MAX) ? DEB_MAX : deb_raw;
  assign pct_raw = wr_data[PCT_W-1:0];

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IAMBIC_B;
      open_r  <= '0;
      close_r <= '0;
      deb_r   <= DEB_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_MODE: begin
          if (wr_data[1:0] <= MODE_ULTIMATIC) mode_r <= mode_t'(wr_data[1:0]);
        end
        REG_WIN_OPEN: begin
          if (pct_raw <= PCT_FULL) open_r <= pct_raw;
        end
        REG_WIN_CLOSE: begin
          if (pct_raw <= PCT_FULL) close_r <= pct_raw;
        end
        REG_DEBOUNCE: begin
          deb_r <= deb_sat;
        end
        default: ;
      endcase
    end
  end

  assign cfg.mode      = mode_r;
  assign cfg.win_open  = open_r;
  assign cfg.win_close = close_r;
  assign cfg.debounce  = deb_r;

  assign spd.wr  = wr_en && (wr_index == REG_WPM);
  assign spd.wpm = wpm_sat;

endmodule

`default_nettype wire

// ----- rtl/iambic_morse_keyer_core.sv -----
// ----------------------------------------------------------------------------
// iambic_morse_keyer_core
// Iambic Morse keyer: paddle debounce, element timing and, in iambic B mode,
// memory latch and squeeze alternation, driven by timestamped ticks.
// ----------------------------------------------------------------------------
// Each input request is one tick; it yields exactly one output request. A
// tick passes through the debounce, evaluate and finish steps. While a dot
// or dash is sounding in iambic B mode with the opposite paddle held and no
// element latched, the element progress percentage first goes through the
// shared one bit per cycle divider. A speed write recomputes the dot length
// on the same divider and keeps the block busy until it is done. Input and
// configuration are taken one at a time, only while the sequencer is idle;
// the output register lets the next tick enter while a result waits.
`default_nettype none

module iambic_morse_keyer_core (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // tick input: [31:0] time_now_us, [32] dot_pin_level, [33] dash_pin_level
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [39:0]                 in_tdata,
  // result: [0] key_out, [2:1] element_done, [3] dot_held, [4] dash_held
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [7:0]                       out_tdata,
  // register writes
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [ikey_pkg::IDX_W-1:0]  cfg_index,
  input  wire logic [ikey_pkg::CFG_W-1:0]  cfg_data
);
  import ikey_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DEB  = 6'b000010,
    S_EVAL = 6'b000100,
    S_DIV  = 6'b001000,
    S_FIN  = 6'b010000,
    S_SPD  = 6'b100000
  } seq_t;

  seq_t seq_r, seq_nxt;

  cfg_t      cfg;
  spd_wr_t   spd;
  div_req_t  div_req;
  div_rsp_t  div_rsp;
  logic      cfg_wr;

  // tick registers
  logic [TIME_W-1:0] now_r;
  logic              dot_raw_r;
  logic              dash_raw_r;
  logic [TIME_W-1:0] elapsed_r;
  logic              win_chk_r;

  // keyer state
  phase_t            phase_r, phase_nxt;
  elem_t             cur_r, cur_nxt;
  elem_t             latch_r, latch_nxt;
  logic [TIME_W-1:0] start_r, start_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic              key_r, key_nxt;
  logic [DOT_W-1:0]  dot_len_r;
  logic              dot_db_r;
  logic              dash_db_r;
  logic [TIME_W-1:0] dot_chg_r;
  logic [TIME_W-1:0] dash_chg_r;

  // output register
  logic              out_valid_r;
  logic              out_key_r;
  elem_t             out_done_r;
  logic              out_dot_r;
  logic              out_dash_r;

  logic              in_acc;
  logic              fin_go;
  logic              win_need;
  logic              win_hit;
  logic              el_over;
  logic              dot_upd;
  logic              dash_upd;
  logic [TIME_W-1:0] dot_el;
  logic [TIME_W-1:0] dash_el;
  logic [DIV_NW-1:0] el_ext;
  logic [DIV_NW-1:0] el_x100;
  logic [LEN_W-1:0]  dash_len;
  logic [PCT_W-1:0]  close_pct;
  elem_t             done_el;
  elem_t             begin_el;
  elem_t             next_el;
  logic              begin_go;

  // handshakes: a tick wins over a register write
  assign in_tready = (seq_r == S_IDLE);
  assign cfg_ready = (seq_r == S_IDLE) && !in_tvalid;
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign fin_go    = !out_valid_r || out_tready;

  ikey_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_wr),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg),
    .spd      (spd)
  );

  ikey_div u_div (
    .clk (clk),
    .rst_n (rst_n),
    .req (div_req),
    .rsp (div_rsp)
  );

  // debounce checks
  assign dot_el   = now_r - dot_chg_r;
  assign dash_el  = now_r - dash_chg_r;
  assign dot_upd  = (dot_raw_r != dot_db_r) && (dot_el >= TIME_W'(cfg.debounce));
  assign dash_upd = (dash_raw_r != dash_db_r) && (dash_el >= TIME_W'(cfg.debounce));

  // elapsed*100 as shifts and adds
  assign el_ext  = DIV_NW'(elapsed_r);
  assign el_x100 = (el_ext << 6) + (el_ext << 5) + (el_ext << 2);

  // memory window only matters when the opposite paddle is held
  assign win_need = ((phase_r == PH_DOT) || (phase_r == PH_DASH)) &&
                    (cfg.mode == MODE_IAMBIC_B) && (latch_r == EL_NONE) &&
                    (len_r != '0) &&
                    (((cur_r == EL_DOT) && dash_db_r) || ((cur_r == EL_DASH) && dot_db_r));

  assign close_pct = PCT_FULL - cfg.win_close;
  assign win_hit   = win_chk_r &&
                     (div_rsp.quotient >= DIV_NW'(cfg.win_open)) &&
                     (div_rsp.quotient <= DIV_NW'(close_pct));
  assign el_over   = elapsed_r >= TIME_W'(len_r);
  assign dash_len  = LEN_W'({dot_len_r, 1'b0}) + LEN_W'(dot_len_r);

  // divider requests
  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = el_x100;
    div_req.divisor  = len_r;
    if (seq_r == S_IDLE) begin
      div_req.start    = spd.wr;
      div_req.dividend = DOT_BASE_US;
      div_req.divisor  = DIV_DW'(spd.wpm);
    end else if (seq_r == S_EVAL) begin
      div_req.start    = win_need;
    end
  end

  // sequencer
  always_comb begin
    seq_nxt = seq_r;
    unique case (seq_r)
      S_IDLE: begin
        if (in_acc) seq_nxt = S_DEB;
        else if (spd.wr) seq_nxt = S_SPD;
      end
      S_DEB:  seq_nxt = S_EVAL;
      S_EVAL: seq_nxt = win_need ? S_DIV : S_FIN;
      S_DIV:  if (div_rsp.done) seq_nxt = S_FIN;
      S_FIN:  if (fin_go) seq_nxt = S_IDLE;
      S_SPD:  if (div_rsp.done) seq_nxt = S_IDLE;
      default: seq_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) seq_r <= S_IDLE;
    else        seq_r <= seq_nxt;
  end

  // phase machine next state
  always_comb begin
    phase_nxt = phase_r;
    cur_nxt   = cur_r;
    latch_nxt = latch_r;
    start_nxt = start_r;
    len_nxt   = len_r;
    key_nxt   = key_r;
    done_el   = EL_NONE;
    begin_go  = 1'b0;
    begin_el  = EL_DOT;
    next_el   = EL_NONE;
    unique case (phase_r)
      PH_IDLE: begin
        if (dot_db_r) begin
          begin_go = 1'b1;
          begin_el = EL_DOT;
        end else if (dash_db_r) begin
          begin_go = 1'b1;
          begin_el = EL_DASH;
        end
      end
      PH_DOT, PH_DASH: begin
        // memory latch catches the opposite paddle
        if (win_hit) begin
          if ((cur_r == EL_DOT) && dash_db_r) latch_nxt = EL_DASH;
          else if ((cur_r == EL_DASH) && dot_db_r) latch_nxt = EL_DOT;
        end
        if (el_over) begin
          done_el   = cur_r;
          key_nxt   = 1'b0;
          phase_nxt = PH_GAP;
          start_nxt = now_r;
          len_nxt   = LEN_W'(dot_len_r);
        end
      end
      PH_GAP: begin
        if (el_over) begin
          if (cfg.mode == MODE_IAMBIC_B) begin
            if (latch_r != EL_NONE) begin
              next_el   = latch_r;
              latch_nxt = EL_NONE;
            end else if (dot_db_r && !dash_db_r) begin
              next_el = EL_DOT;
            end else if (dash_db_r && !dot_db_r) begin
              next_el = EL_DASH;
            end else if (dot_db_r && dash_db_r) begin
              next_el = (cur_r == EL_DOT) ? EL_DASH : EL_DOT;
            end
          end
          if (next_el != EL_NONE) begin
            begin_go = 1'b1;
            begin_el = next_el;
          end else begin
            phase_nxt = PH_IDLE;
            cur_nxt   = EL_NONE;
            key_nxt   = 1'b0;
          end
        end
      end
      default: ;
    endcase
    // start of a new element
    if (begin_go) begin
      cur_nxt   = begin_el;
      start_nxt = now_r;
      key_nxt   = 1'b1;
      if (begin_el == EL_DOT) begin
        phase_nxt = PH_DOT;
        len_nxt   = LEN_W'(dot_len_r);
      end else begin
        phase_nxt = PH_DASH;
        len_nxt   = dash_len;
      end
    end
  end

  // tick capture and per-tick scratch
  always_ff @(posedge clk) begin
    if (in_acc) begin
      now_r      <= in_tdata[31:0];
      dot_raw_r  <= ~in_tdata[32];
      dash_raw_r <= ~in_tdata[33];
    end
    if (seq_r == S_DEB) elapsed_r <= now_r - start_r;
    if (seq_r == S_EVAL) win_chk_r <= win_need;
  end

  // keyer state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      cur_r      <= EL_NONE;
      latch_r    <= EL_NONE;
      start_r    <= '0;
      len_r      <= '0;
      key_r      <= 1'b0;
      dot_len_r  <= DOT_RESET_US;
      dot_db_r   <= 1'b0;
      dash_db_r  <= 1'b0;
      dot_chg_r  <= '0;
      dash_chg_r <= '0;
    end else begin
      if (seq_r == S_DEB) begin
        if (dot_upd) begin
          dot_db_r  <= dot_raw_r;
          dot_chg_r <= now_r;
        end
        if (dash_upd) begin
          dash_db_r  <= dash_raw_r;
          dash_chg_r <= now_r;
        end
      end
      if ((seq_r == S_FIN) && fin_go) begin
        phase_r <= phase_nxt;
        cur_r   <= cur_nxt;
        latch_r <= latch_nxt;
        start_r <= start_nxt;
        len_r   <= len_nxt;
        key_r   <= key_nxt;
      end
      if ((seq_r == S_SPD) && div_rsp.done) dot_len_r <= div_rsp.quotient[DOT_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((seq_r == S_FIN) && fin_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((seq_r == S_FIN) && fin_go) begin
      out_key_r  <= key_nxt;
      out_done_r <= done_el;
      out_dot_r  <= dot_db_r;
      out_dash_r <= dash_db_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_dash_r, out_dot_r, out_done_r, out_key_r};

`ifndef SYNTHESIS
  a_key_in_element: assert property (@(posedge clk) disable iff (!rst_n)
    key_r |-> ((phase_r == PH_DOT) || (phase_r == PH_DASH)))
    else $error("key active outside an element");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> ((cur_r == EL_NONE) && !key_r))
    else $error("idle phase with element or key set");

  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> ((seq_r == S_DIV) || (seq_r == S_SPD)))
    else $error("divider finished with no waiting step");

  a_fin_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    ((seq_r == S_FIN) && fin_go) |=> out_valid_r)
    else $error("finished tick did not reach the output register");
`endif

endmodule

`default_nettype wire

// ----- test/iambic_morse_keyer_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iambic_morse_keyer_core_tb
// Self-checking bench for the iambic keyer core. Timestamped paddle ticks are
// streamed in while the bench tracks its own copy of the debounce, the phase
// machine and the memory latch. Every result is checked field by field
// against that prediction, under random source gaps, sink stalls, long sink
// hold-offs and a series of register settings, the extremes among them.
// ----------------------------------------------------------------------------

module iambic_morse_keyer_core_tb;

  import ikey_pkg::*;

  localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [WPM_W-1:0] WPM_RESET  = 6'd20;
  localparam int unsigned DASH_DOTS       = 3;
  localparam int unsigned SETTLE_CYCLES   = 64;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned HOLD_CYCLES     = 400;
  localparam int unsigned HOLD_EVERY      = 700;
  localparam int unsigned ITEMS_PER_SET   = 200;
  localparam int unsigned NUM_SETTINGS    = 8;

  typedef struct {
    logic [31:0] stamp;
    logic        dot_lvl;
    logic        dash_lvl;
    int unsigned gap;
  } tick_t;

  typedef struct {
    logic  key;
    elem_t done;
    logic  dot_held;
    logic  dash_held;
  } keyer_out_t;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [39:0]       in_tdata   = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [7:0]        out_tdata;
  logic              cfg_valid  = 1'b0;
  logic              cfg_ready;
  logic [IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_W-1:0]  cfg_data   = '0;

  iambic_morse_keyer_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // keyer shadow: registers
  logic [WPM_W-1:0] cfg_wpm;
  mode_t            cfg_mode;
  logic [PCT_W-1:0] cfg_open;
  logic [PCT_W-1:0] cfg_close;
  logic [DEB_W-1:0] cfg_deb;

  // keyer shadow: state
  phase_t           kp_phase;
  elem_t            kp_elem;
  elem_t            kp_memory;
  logic [31:0]      kp_start;
  logic [31:0]      kp_len;
  logic [DOT_W-1:0] kp_dot_len;
  logic             dot_db;
  logic             dash_db;
  logic [31:0]      dot_chg;
  logic [31:0]      dash_chg;
  logic             kp_keying;

  tick_t       pending_ticks[$];
  keyer_out_t  expected_keying[$];

  int unsigned n_errors    = 0;
  int unsigned n_ticks     = 0;
  int unsigned n_results   = 0;
  int unsigned n_dots      = 0;
  int unsigned n_dashes    = 0;
  int unsigned n_latched   = 0;
  int unsigned n_writes    = 0;
  int unsigned n_generated = 0;

  logic        in_fire      = 1'b0;
  logic        out_fire     = 1'b0;
  int unsigned in_wait      = 0;
  int unsigned rx_wait      = 0;
  int unsigned hold_left    = 0;
  int unsigned next_hold_at = 250;
  int unsigned idle_cycles  = 0;

  // speed write: saturate, then dot length from the base constant
  function automatic void set_speed(logic [WPM_W-1:0] w);
    logic [WPM_W-1:0] s;
    s = w;
    if (s < WPM_MIN) s = WPM_MIN;
    if (s > WPM_MAX) s = WPM_MAX;
    cfg_wpm    = s;
    kp_dot_len = DOT_W'(DOT_BASE_US / s);
  endfunction

  function automatic void reset_keyer();
    cfg_mode  = MODE_IAMBIC_B;
    cfg_open  = '0;
    cfg_close = '0;
    cfg_deb   = DEB_RESET;
    set_speed(WPM_RESET);
    kp_phase  = PH_IDLE;
    kp_elem   = EL_NONE;
    kp_memory = EL_NONE;
    kp_start  = '0;
    kp_len    = '0;
    dot_db    = 1'b0;
    dash_db   = 1'b0;
    dot_chg   = '0;
    dash_chg  = '0;
    kp_keying = 1'b0;
  endfunction

  function automatic void apply_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    logic [DEB_W-1:0] d;
    case (idx)
      REG_WPM: set_speed(val[WPM_W-1:0]);
      REG_MODE: if (val[1:0] <= MODE_ULTIMATIC) cfg_mode = mode_t'(val[1:0]);
      REG_WIN_OPEN: if (val[PCT_W-1:0] <= PCT_FULL) cfg_open = val[PCT_W-1:0];
      REG_WIN_CLOSE: if (val[PCT_W-1:0] <= PCT_FULL) cfg_close = val[PCT_W-1:0];
      REG_DEBOUNCE: begin
        d = val[DEB_W-1:0];
        if (d < DEB_MIN) d = DEB_MIN;
        if (d > DEB_MAX) d = DEB_MAX;
        cfg_deb = d;
      end
      default: ;
    endcase
  endfunction

  function automatic void begin_element(elem_t el, logic [31:0] now);
    kp_elem  = el;
    kp_start = now;
    if (el == EL_DOT) begin
      kp_phase = PH_DOT;
      kp_len   = 32'(kp_dot_len);
    end else begin
      kp_phase = PH_DASH;
      kp_len   = 32'(kp_dot_len) * DASH_DOTS;
    end
    kp_keying = 1'b1;
  endfunction

  // progress in percent at full width; a zero length never opens the window
  function automatic bit in_window(logic [31:0] elapsed);
    logic [63:0] progress;
    if (kp_len == 0) return 1'b0;
    progress = (64'(elapsed) * 64'(PCT_FULL)) / 64'(kp_len);
    return progress >= 64'(cfg_open) && progress <= 64'(PCT_FULL - cfg_close);
  endfunction

  // end of the inter-element gap: in iambic B memory first, then paddles, squeeze alternates; else idle
  function automatic void after_gap(logic [31:0] now);
    elem_t nxt;
    nxt = EL_NONE;
    if (cfg_mode == MODE_IAMBIC_B) begin
      if (kp_memory != EL_NONE) begin
        nxt       = kp_memory;
        kp_memory = EL_NONE;
      end else if (dot_db && !dash_db) begin
        nxt = EL_DOT;
      end else if (dash_db && !dot_db) begin
        nxt = EL_DASH;
      end else if (dot_db && dash_db) begin
        nxt = (kp_elem == EL_DOT) ? EL_DASH : EL_DOT;
      end
    end
    if (nxt != EL_NONE) begin
      begin_element(nxt, now);
    end else begin
      kp_phase  = PH_IDLE;
      kp_elem   = EL_NONE;
      kp_keying = 1'b0;
    end
  endfunction

  // one tick through debounce and phase machine
  function automatic keyer_out_t predict_tick(logic [31:0] now, logic dot_lvl, logic dash_lvl);
    logic        dot_raw;
    logic        dash_raw;
    logic [31:0] since;
    logic [31:0] elapsed;
    elem_t       done;
    keyer_out_t  r;
    dot_raw  = !dot_lvl;
    dash_raw = !dash_lvl;
    done     = EL_NONE;
    since = now - dot_chg;
    if (dot_raw != dot_db && since >= 32'(cfg_deb)) begin
      dot_db  = dot_raw;
      dot_chg = now;
    end
    since = now - dash_chg;
    if (dash_raw != dash_db && since >= 32'(cfg_deb)) begin
      dash_db  = dash_raw;
      dash_chg = now;
    end
    elapsed = now - kp_start;
    case (kp_phase)
      PH_IDLE: begin
        if (dot_db) begin_element(EL_DOT, now);
        else if (dash_db) begin_element(EL_DASH, now);
      end
      PH_DOT, PH_DASH: begin
        if (cfg_mode == MODE_IAMBIC_B && kp_memory == EL_NONE && in_window(elapsed)) begin
          if (kp_elem == EL_DOT && dash_db) kp_memory = EL_DASH;
          else if (kp_elem == EL_DASH && dot_db) kp_memory = EL_DOT;
          if (kp_memory != EL_NONE) n_latched++;
        end
        if (elapsed >= kp_len) begin
          done      = kp_elem;
          kp_keying = 1'b0;
          kp_phase  = PH_GAP;
          kp_start  = now;
          kp_len    = 32'(kp_dot_len);
        end
      end
      default: begin
        if (elapsed >= kp_len) after_gap(now);
      end
    endcase
    r.key       = kp_keying;
    r.done      = done;
    r.dot_held  = dot_db;
    r.dash_held = dash_db;
    return r;
  endfunction

  // result check, then prediction of the tick accepted at this edge
  always @(posedge clk) begin
    keyer_out_t got;
    keyer_out_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.key       = out_tdata[0];
        got.done      = elem_t'(out_tdata[2:1]);
        got.dot_held  = out_tdata[3];
        got.dash_held = out_tdata[4];
        n_results++;
        if (got.done == EL_DOT) n_dots++;
        if (got.done == EL_DASH) n_dashes++;
        if (expected_keying.size() == 0) begin
          $error("result with no request pending: out_tdata %h", out_tdata);
          n_errors++;
        end else begin
          want = expected_keying.pop_front();
          if (got.key !== want.key) begin
            $error("key_out: expected %0d, got %0d", want.key, got.key);
            n_errors++;
          end
          if (got.done !== want.done) begin
            $error("element_done: expected %0d, got %0d", want.done, got.done);
            n_errors++;
          end
          if (got.dot_held !== want.dot_held) begin
            $error("dot_held: expected %0d, got %0d", want.dot_held, got.dot_held);
            n_errors++;
          end
          if (got.dash_held !== want.dash_held) begin
            $error("dash_held: expected %0d, got %0d", want.dash_held, got.dash_held);
            n_errors++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        expected_keying.push_back(predict_tick(in_tdata[31:0], in_tdata[32], in_tdata[33]));
        n_ticks++;
      end
    end
    in_fire  <= rst_n && in_tvalid && in_tready;
    out_fire <= rst_n && out_tvalid && out_tready;
  end

  // tick source: holds a request until taken, then waits out its gap
  always @(negedge clk) begin
    tick_t t;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_fire) begin
      in_tvalid <= 1'b1;
    end else if (in_wait > 0) begin
      in_wait   <= in_wait - 1;
      in_tvalid <= 1'b0;
    end else if (pending_ticks.size() > 0) begin
      t = pending_ticks.pop_front();
      in_tdata  <= {6'b0, t.dash_lvl, t.dot_lvl, t.stamp};
      in_tvalid <= 1'b1;
      in_wait   <= t.gap;
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // result sink: random stalls, stall-free stretches, long hold-offs
  always @(negedge clk) begin
    int unsigned s;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (n_results >= next_hold_at) begin
      hold_left    <= HOLD_CYCLES;
      next_hold_at <= next_hold_at + HOLD_EVERY;
      out_tready   <= 1'b0;
    end else if (out_fire) begin
      s = ((n_results % 400) < 120) ? 0 : $urandom_range(0, 6);
      out_tready <= (s == 0);
      rx_wait    <= (s == 0) ? 0 : s - 1;
    end else if (rx_wait > 0) begin
      rx_wait    <= rx_wait - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // watchdog on cycles with no request taken anywhere
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no request taken for %0d cycles", WATCHDOG_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // source gaps, with stretches that send back to back
  function automatic int unsigned draw_gap();
    return ((n_generated % 300) < 80) ? 0 : $urandom_range(0, 6);
  endfunction

  task automatic push_tick(logic [31:0] stamp, logic dot_lvl, logic dash_lvl);
    tick_t t;
    t.stamp    = stamp;
    t.dot_lvl  = dot_lvl;
    t.dash_lvl = dash_lvl;
    t.gap      = draw_gap();
    pending_ticks.push_back(t);
    n_generated++;
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, val);
    n_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // all ticks taken, all results back, then let the divider settle
  task automatic wait_drain();
    while (pending_ticks.size() != 0 || in_tvalid || expected_keying.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // paddle sessions: mostly held paddles, squeezes and memory taps, some noise
  task automatic gen_keying(inout logic [31:0] stamp, input int unsigned n_items);
    int unsigned made;
    int unsigned pat;
    int unsigned dur;
    int unsigned k;
    logic        dp;
    logic        hp;
    logic        base_dot;
    made = 0;
    while (made < n_items) begin
      pat      = $urandom_range(0, 15);
      dur      = (pat == 15) ? 1 : $urandom_range(2, 14);
      base_dot = 1'($urandom_range(0, 1));
      for (k = 0; k < dur && made < n_items; k++) begin
        case (pat)
          0, 1, 2, 3: begin dp = 1'b0; hp = 1'b1; end
          4, 5, 6:    begin dp = 1'b1; hp = 1'b0; end
          7, 8, 9:    begin dp = 1'b0; hp = 1'b0; end
          10: begin
            // one paddle held, the other tapped briefly mid element
            dp = base_dot ? 1'b0 : !(k == 1 || k == 2);
            hp = base_dot ? !(k == 1 || k == 2) : 1'b0;
          end
          11, 12:     begin dp = 1'b1; hp = 1'b1; end
          default: begin
            dp = 1'($urandom_range(0, 1));
            hp = 1'($urandom_range(0, 1));
          end
        endcase
        if (pat == 13) stamp = stamp + $urandom_range(0, 300);
        else if (pat == 15) stamp = $urandom();
        else stamp = stamp + 32'(kp_dot_len) / $urandom_range(1, 5) + $urandom_range(0, 999);
        push_tick(stamp, dp, hp);
        made++;
      end
    end
  endtask

  initial begin
    logic [31:0] stamp;
    int unsigned set_no;
    reset_keyer();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed ticks at reset settings: 60 ms dot, 1 ms debounce, iambic b
    push_tick(32'd0, 1'b1, 1'b1);
    push_tick(32'hFFFF_FFFF, 1'b1, 1'b1);
    push_tick(32'd2000, 1'b0, 1'b0);        // squeeze from idle starts a dot
    push_tick(32'd30000, 1'b0, 1'b0);       // dash caught in memory
    push_tick(32'd62000, 1'b0, 1'b0);       // dot ends
    push_tick(32'd122000, 1'b0, 1'b0);      // gap ends, memory dash
    push_tick(32'd122500, 1'b1, 1'b1);      // release taken
    push_tick(32'd124000, 1'b1, 1'b1);      // paddles stay released
    push_tick(32'd302000, 1'b1, 1'b1);
    push_tick(32'd362000, 1'b1, 1'b1);
    push_tick(32'd422000, 1'b1, 1'b1);
    push_tick(32'd482000, 1'b1, 1'b1);      // still idle
    push_tick(32'd500000, 1'b1, 1'b0);      // dash alone
    push_tick(32'd560000, 1'b0, 1'b0);      // dot tapped during dash
    push_tick(32'd580000, 1'b1, 1'b0);
    push_tick(32'd680000, 1'b1, 1'b0);
    push_tick(32'd680000, 1'b1, 1'b0);      // repeated timestamp
    push_tick(32'd740000, 1'b1, 1'b0);
    push_tick(32'd100, 1'b1, 1'b1);         // timestamp goes backwards
    push_tick(32'hFFFF_F000, 1'b1, 1'b0);
    push_tick(32'h0000_0800, 1'b1, 1'b0);   // elapsed across the wrap
    push_tick(32'h0002_0000, 1'b1, 1'b1);
    wait_drain();

    stamp = 32'h0010_0000;
    for (set_no = 0; set_no < NUM_SETTINGS; set_no++) begin
      case (set_no)
        0: begin
          // fastest speed via saturation, iambic a, shortest debounce
          write_reg(REG_WPM, 14'd63);
          write_reg(REG_MODE, 14'(MODE_IAMBIC_A));
          write_reg(REG_WIN_OPEN, 14'd0);
          write_reg(REG_WIN_CLOSE, 14'd0);
          write_reg(REG_DEBOUNCE, 14'd0);
        end
        1: begin
          // slowest speed, window open only at full progress, longest debounce
          write_reg(REG_WPM, 14'd0);
          write_reg(REG_MODE, 14'(MODE_IAMBIC_B));
          write_reg(REG_WIN_OPEN, 14'(PCT_FULL));
          write_reg(REG_WIN_CLOSE, 14'd0);
          write_reg(REG_DEBOUNCE, 14'h3FFF);
        end
        2: begin
          write_reg(REG_WPM, 14'd13);
          write_reg(REG_MODE, 14'(MODE_ULTIMATIC));
          write_reg(REG_WIN_OPEN, 14'd30);
          write_reg(REG_WIN_CLOSE, 14'(PCT_FULL));
          write_reg(REG_DEBOUNCE, 14'd500);
        end
        3: begin
          // upper data bits dropped, unknown mode and big percents ignored
          write_reg(REG_WPM, 14'h3FD9);
          write_reg(REG_MODE, 14'(MODE_IAMBIC_B));
          write_reg(REG_MODE, 14'h3FFF);
          write_reg(REG_WIN_OPEN, 14'd10);
          write_reg(REG_WIN_CLOSE, 14'd25);
          write_reg(REG_WIN_OPEN, 14'h007F);
          write_reg(REG_WIN_CLOSE, 14'd101);
          write_reg(REG_UNUSED, 14'h2AAA);
          write_reg(REG_DEBOUNCE, 14'd10000);
        end
        default: begin
          write_reg(REG_WPM, 14'($urandom_range(5, 60)));
          write_reg(REG_MODE, ($urandom_range(0, 3) == 0) ? 14'(MODE_IAMBIC_A)
                                                          : 14'(MODE_IAMBIC_B));
          write_reg(REG_WIN_OPEN, 14'($urandom_range(0, 70)));
          write_reg(REG_WIN_CLOSE, 14'($urandom_range(0, 70)));
          write_reg(REG_DEBOUNCE, 14'($urandom_range(50, 12000)));
        end
      endcase
      // this set runs across the timestamp wrap
      if (set_no == 4) stamp = 32'hFFF0_0000;
      gen_keying(stamp, ITEMS_PER_SET);
      wait_drain();
    end

    $display("run: %0d ticks, %0d results, %0d register writes over %0d settings",
             n_ticks, n_results, n_writes, NUM_SETTINGS + 1);
    $display("run: %0d dots and %0d dashes keyed, %0d memory latches taken",
             n_dots, n_dashes, n_latched);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/ikey_pkg.sv
rtl/ikey_div.sv
rtl/ikey_cfg.sv
rtl/iambic_morse_keyer_core.sv
test/iambic_morse_keyer_core_tb.sv
